// ===== rtl/ljpv_pkg.sv =====
// Shared types and constants for the Lennard-Jones pair kernel.
package ljpv_pkg;

    // Number of axes taken into the distance sum.
    localparam int DIMS = 3;

    // Steps of the restoring divider that forms 1/r^2.
    localparam int DIV_STEPS = 64;

    // Number of chained Q32.32 products (sr4, sr6, sr12).
    localparam int NUM_QMUL = 3;

    localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMAX_DIV4 = SMAX >> 2;
    localparam logic [63:0] SMAX_DIV8 = SMAX >> 3;

    // 1/r^2 above the limit is an overlap: limit * r^2 below 2^48.
    localparam logic [64:0] OVL_BOUND = 65'h1_0000_0000_0000;

    // Register map, word index (byte address / 4).
    typedef enum logic [2:0] {
        REG_BOX_X   = 3'd0,
        REG_BOX_Y   = 3'd1,
        REG_BOX_Z   = 3'd2,
        REG_CUT_SQ  = 3'd3,
        REG_OVL_LIM = 3'd4
    } t_reg_idx;

    // Per-word outcome flags traveling with the data.
    typedef struct packed {
        logic ovl;     // overlap or coincident
        logic in_cut;  // within cutoff
        logic sat;     // a power product reached 2^64
    } t_flags;

endpackage

// ===== rtl/lj_pair_potential_virial.sv =====
// Lennard-Jones pair potential and virial kernel, pipelined, stream in/out.
//
// One pair of particle positions enters per clock and one result word
// leaves per clock while downstream keeps up; pairs overlap in the pipeline.
// From input accept to output valid a word passes six stages of
// minimum image, scaling, squaring and overlap/cutoff tests, a 64-stage
// restoring divider (one quotient bit per stage) forming 1/r^2 in Q32.32,
// three 3-stage Q32.32 multipliers for sr4, sr6 and sr12, one stage for the
// final energy/virial, and the output register. The divider sets the depth.
// Downstream backpressure does not freeze the pipeline at once: a
// second output register (skid) catches the word that was in flight, and
// s_axis_tready is that skid register's empty flag. Positions are signed
// Q0.32 box fractions; the wrapped 32-bit difference is the minimum image.
// Energy and virial are signed Q32.32, saturating to +max; on overlap both
// are zero and tuser[0] is set; beyond cutoff both are zero. Configuration
// (APB, byte addresses 0x00 box x, 0x04 box y, 0x08 box z, 0x0C cutoff^2,
// 0x10 overlap limit, all Q16.16) may be written only while idle.
module lj_pair_potential_virial (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB config port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // pair_energy, pair_virial
    output logic [0:0]   m_axis_tuser   // overlap
);

    // ---------------- configuration ----------------
    logic [31:0] r_box [ljpv_pkg::DIMS];
    logic [31:0] r_cut_sq;
    logic [31:0] r_ovl_lim;
    ljpv_pkg::t_reg_idx w_idx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_idx  = ljpv_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ljpv_pkg::DIMS; i++) r_box[i] <= 32'd655360;
            r_cut_sq  <= 32'd409600;
            r_ovl_lim <= 32'd65536;
        end else if (w_wr) begin
            unique case (w_idx)
                ljpv_pkg::REG_BOX_X:   r_box[0]  <= pwdata;
                ljpv_pkg::REG_BOX_Y:   r_box[1]  <= pwdata;
                ljpv_pkg::REG_BOX_Z:   r_box[2]  <= pwdata;
                ljpv_pkg::REG_CUT_SQ:  r_cut_sq  <= pwdata;
                ljpv_pkg::REG_OVL_LIM: r_ovl_lim <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ljpv_pkg::REG_BOX_X:   prdata = r_box[0];
            ljpv_pkg::REG_BOX_Y:   prdata = r_box[1];
            ljpv_pkg::REG_BOX_Z:   prdata = r_box[2];
            ljpv_pkg::REG_CUT_SQ:  prdata = r_cut_sq;
            ljpv_pkg::REG_OVL_LIM: prdata = r_ovl_lim;
            default:               prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    // Whole pipeline advances unless the skid register is holding a word.
    logic r_skid_vld;
    logic w_en;
    logic w_in_acc;

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;
    assign w_in_acc      = s_axis_tvalid && w_en;

    // ---------------- S1: minimum image magnitude ----------------
    logic        r_s1_vld;
    logic [31:0] r_s1_mag [ljpv_pkg::DIMS];
    logic [31:0] w_diff   [ljpv_pkg::DIMS];

    always_comb begin
        for (int i = 0; i < ljpv_pkg::DIMS; i++) begin
            w_diff[i] = s_axis_tdata[32*i +: 32] - s_axis_tdata[96 + 32*i +: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // wrap of -0.5 gives 2^31, which is the wanted magnitude
            for (int i = 0; i < ljpv_pkg::DIMS; i++) begin
                r_s1_mag[i] <= w_diff[i][31] ? (32'd0 - w_diff[i]) : w_diff[i];
            end
        end
    end

    // ---------------- S2: scale by box ----------------
    logic        r_s2_vld;
    logic [31:0] r_s2_dr [ljpv_pkg::DIMS];
    logic [63:0] w_scl   [ljpv_pkg::DIMS];

    always_comb begin
        for (int i = 0; i < ljpv_pkg::DIMS; i++) begin
            w_scl[i] = 64'(r_s1_mag[i]) * 64'(r_box[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < ljpv_pkg::DIMS; i++) r_s2_dr[i] <= w_scl[i][63:32];
        end
    end

    // ---------------- S3: square ----------------
    logic        r_s3_vld;
    logic [63:0] r_s3_sq [ljpv_pkg::DIMS];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < ljpv_pkg::DIMS; i++) begin
                r_s3_sq[i] <= 64'(r_s2_dr[i]) * 64'(r_s2_dr[i]);
            end
        end
    end

    // ---------------- S4: r^2 sum ----------------
    logic        r_s4_vld;
    logic [63:0] r_s4_r2;
    logic [63:0] w_r2;

    always_comb begin
        w_r2 = 64'd0;
        for (int i = 0; i < ljpv_pkg::DIMS; i++) w_r2 = w_r2 + r_s3_sq[i];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_s4_r2 <= w_r2;
    end

    // ---------------- S5: overlap partials, cutoff test ----------------
    logic        r_s5_vld;
    logic [63:0] r_s5_r2;
    logic [63:0] r_s5_pl;
    logic [63:0] r_s5_ph;
    logic        r_s5_zero;
    logic        r_s5_in;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_r2   <= r_s4_r2;
            r_s5_pl   <= 64'(r_ovl_lim) * 64'(r_s4_r2[31:0]);
            r_s5_ph   <= 64'(r_ovl_lim) * 64'(r_s4_r2[63:32]);
            r_s5_zero <= (r_s4_r2 == 64'd0);
            r_s5_in   <= (r_s4_r2 < {16'd0, r_cut_sq, 16'd0});
        end
    end

    // ---------------- S6: overlap decision ----------------
    logic [64:0] w_ovl_sum;
    logic        w_ovl;

    assign w_ovl_sum = {1'b0, r_s5_pl} + {1'b0, r_s5_ph[15:0], 32'd0};
    assign w_ovl     = r_s5_zero ||
                       ((r_s5_ph[63:16] == 48'd0) && (w_ovl_sum < ljpv_pkg::OVL_BOUND));

    // ---------------- divider: sr2 = (2^64-1) / r^2 ----------------
    // stage 0 is the S6 register; each later stage adds one quotient bit
    logic                 r_dv_vld [ljpv_pkg::DIV_STEPS+1];
    logic [63:0]          r_dv_rem [ljpv_pkg::DIV_STEPS+1];
    logic [63:0]          r_dv_q   [ljpv_pkg::DIV_STEPS+1];
    logic [63:0]          r_dv_den [ljpv_pkg::DIV_STEPS+1];
    ljpv_pkg::t_flags     r_dv_fl  [ljpv_pkg::DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_rem[0]        <= 64'd0;
            r_dv_q[0]          <= 64'd0;
            r_dv_den[0]        <= r_s5_r2;
            r_dv_fl[0].ovl     <= w_ovl;
            r_dv_fl[0].in_cut  <= r_s5_in;
            r_dv_fl[0].sat     <= 1'b0;
        end
    end

    for (genvar k = 0; k < ljpv_pkg::DIV_STEPS; k++) begin : g_div
        logic [64:0] w_t;
        logic [64:0] w_sub;
        assign w_t   = {r_dv_rem[k], 1'b1};  // dividend is all ones
        assign w_sub = w_t - {1'b0, r_dv_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k+1] <= w_sub[64] ? w_t[63:0] : w_sub[63:0];
                r_dv_q[k+1]   <= {r_dv_q[k][62:0], !w_sub[64]};
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_fl[k+1]  <= r_dv_fl[k];
            end
        end
    end

    // ---------------- Q32.32 multipliers: sr4, sr6, sr12 ----------------
    // each: partial products, middle/high sums, final carry and saturation
    logic             w_q_vld [ljpv_pkg::NUM_QMUL];
    logic [63:0]      w_q_a   [ljpv_pkg::NUM_QMUL];
    logic [63:0]      w_q_b   [ljpv_pkg::NUM_QMUL];
    logic [63:0]      w_q_aux [ljpv_pkg::NUM_QMUL];
    ljpv_pkg::t_flags w_q_fl  [ljpv_pkg::NUM_QMUL];

    logic             r_qp_vld [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qp_ll  [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qp_lh  [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qp_hl  [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qp_hh  [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qp_aux [ljpv_pkg::NUM_QMUL];
    ljpv_pkg::t_flags r_qp_fl  [ljpv_pkg::NUM_QMUL];

    logic             r_qm_vld [ljpv_pkg::NUM_QMUL];
    logic [33:0]      r_qm_mid [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qm_hs  [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qm_aux [ljpv_pkg::NUM_QMUL];
    ljpv_pkg::t_flags r_qm_fl  [ljpv_pkg::NUM_QMUL];

    logic             r_qf_vld [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qf_val [ljpv_pkg::NUM_QMUL];
    logic [63:0]      r_qf_aux [ljpv_pkg::NUM_QMUL];
    ljpv_pkg::t_flags r_qf_fl  [ljpv_pkg::NUM_QMUL];

    // sr4 = sr2*sr2 (carry sr2), sr6 = sr4*sr2, sr12 = sr6*sr6 (carry sr6)
    always_comb begin
        w_q_vld[0] = r_dv_vld[ljpv_pkg::DIV_STEPS];
        w_q_a[0]   = r_dv_q[ljpv_pkg::DIV_STEPS];
        w_q_b[0]   = r_dv_q[ljpv_pkg::DIV_STEPS];
        w_q_aux[0] = r_dv_q[ljpv_pkg::DIV_STEPS];
        w_q_fl[0]  = r_dv_fl[ljpv_pkg::DIV_STEPS];
        w_q_vld[1] = r_qf_vld[0];
        w_q_a[1]   = r_qf_val[0];
        w_q_b[1]   = r_qf_aux[0];
        w_q_aux[1] = r_qf_aux[0];
        w_q_fl[1]  = r_qf_fl[0];
        w_q_vld[2] = r_qf_vld[1];
        w_q_a[2]   = r_qf_val[1];
        w_q_b[2]   = r_qf_val[1];
        w_q_aux[2] = r_qf_val[1];
        w_q_fl[2]  = r_qf_fl[1];
    end

    for (genvar k = 0; k < ljpv_pkg::NUM_QMUL; k++) begin : g_qmul
        logic [63:0] w_hi;
        logic        w_ovf;
        assign w_hi  = r_qm_hs[k] + 64'(r_qm_mid[k][33:32]);
        assign w_ovf = (w_hi[63:32] != 32'd0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qp_vld[k] <= 1'b0;
                r_qm_vld[k] <= 1'b0;
                r_qf_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_qp_vld[k] <= w_q_vld[k];
                r_qm_vld[k] <= r_qp_vld[k];
                r_qf_vld[k] <= r_qm_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_qp_ll[k]  <= 64'(w_q_a[k][31:0])  * 64'(w_q_b[k][31:0]);
                r_qp_lh[k]  <= 64'(w_q_a[k][31:0])  * 64'(w_q_b[k][63:32]);
                r_qp_hl[k]  <= 64'(w_q_a[k][63:32]) * 64'(w_q_b[k][31:0]);
                r_qp_hh[k]  <= 64'(w_q_a[k][63:32]) * 64'(w_q_b[k][63:32]);
                r_qp_aux[k] <= w_q_aux[k];
                r_qp_fl[k]  <= w_q_fl[k];

                r_qm_mid[k] <= 34'(r_qp_ll[k][63:32]) + 34'(r_qp_lh[k][31:0])
                             + 34'(r_qp_hl[k][31:0]);
                r_qm_hs[k]  <= r_qp_hh[k] + 64'(r_qp_lh[k][63:32])
                             + 64'(r_qp_hl[k][63:32]);
                r_qm_aux[k] <= r_qp_aux[k];
                r_qm_fl[k]  <= r_qp_fl[k];

                r_qf_val[k]       <= w_ovf ? '1 : {w_hi[31:0], r_qm_mid[k][31:0]};
                r_qf_aux[k]       <= r_qm_aux[k];
                r_qf_fl[k].ovl    <= r_qm_fl[k].ovl;
                r_qf_fl[k].in_cut <= r_qm_fl[k].in_cut;
                r_qf_fl[k].sat    <= r_qm_fl[k].sat || w_ovf;
            end
        end
    end

    // ---------------- final: energy and virial ----------------
    logic        r_z_vld;
    logic [63:0] r_z_pot;
    logic [63:0] r_z_vir;
    logic        r_z_ovl;
    logic [63:0] w_pot;
    logic [63:0] w_vir;

    always_comb begin
        logic [63:0] v_sr12;
        logic [63:0] v_sr6;
        logic [63:0] v_d;
        logic [63:0] v_t;
        ljpv_pkg::t_flags v_fl;
        v_sr12 = r_qf_val[2];
        v_sr6  = r_qf_aux[2];
        v_fl   = r_qf_fl[2];
        v_d    = 64'd0;
        v_t    = 64'd0;
        w_pot  = 64'd0;
        w_vir  = 64'd0;
        if (v_fl.ovl || !v_fl.in_cut) begin
            w_pot = 64'd0;
            w_vir = 64'd0;
        end else if (v_fl.sat) begin
            w_pot = ljpv_pkg::SMAX;
            w_vir = ljpv_pkg::SMAX;
        end else begin
            if (v_sr12 >= v_sr6) begin
                v_d   = v_sr12 - v_sr6;
                w_pot = (v_d > ljpv_pkg::SMAX_DIV4) ? ljpv_pkg::SMAX : (v_d << 2);
            end else begin
                v_d   = v_sr6 - v_sr12;
                w_pot = 64'd0 - (v_d << 2);
            end
            if (v_sr12 > ljpv_pkg::SMAX) begin
                w_vir = ljpv_pkg::SMAX;
            end else begin
                v_t = v_sr12 << 1;
                if (v_t >= v_sr6) begin
                    v_d   = v_t - v_sr6;
                    w_vir = (v_d > ljpv_pkg::SMAX_DIV8) ? ljpv_pkg::SMAX : (v_d << 3);
                end else begin
                    v_d   = v_sr6 - v_t;
                    w_vir = 64'd0 - (v_d << 3);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z_pot <= w_pot;
            r_z_vir <= w_vir;
            r_z_ovl <= r_qf_fl[2].ovl;
        end
    end

    // ---------------- front valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_s5_vld    <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_z_vld     <= 1'b0;
        end else if (w_en) begin
            r_s1_vld    <= w_in_acc;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_s5_vld    <= r_s4_vld;
            r_dv_vld[0] <= r_s5_vld;
            r_z_vld     <= r_qf_vld[2];
        end
    end

    // ---------------- output register and skid ----------------
    logic         r_out_vld;
    logic [127:0] r_out_data;
    logic         r_out_ovl;
    logic [127:0] r_skid_data;
    logic         r_skid_ovl;
    logic         w_out_take;

    assign w_out_take = r_out_vld && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_out_take) begin
            r_out_vld <= r_z_vld;
        end else if (r_z_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_out_take) begin
                r_out_data <= r_skid_data;
                r_out_ovl  <= r_skid_ovl;
            end
        end else if (!r_out_vld || w_out_take) begin
            r_out_data <= {r_z_vir, r_z_pot};
            r_out_ovl  <= r_z_ovl;
        end else begin
            r_skid_data <= {r_z_vir, r_z_pot};
            r_skid_ovl  <= r_z_ovl;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_ovl;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with empty output register");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !m_axis_tready))
        else $error("skid filled without a stalled output");

    a_ovl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ovl) |-> (r_out_data == 128'd0))
        else $error("overlap word carries nonzero energy or virial");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> (r_z_vld == $past(r_z_vld)) && (r_s1_vld == $past(r_s1_vld)))
        else $error("pipeline moved while frozen");
`endif

endmodule
